/* rtl/ipmac_pkg.sv */
package ipmac_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int ADDR_W  = 32;
  localparam int MAC_W   = 48;
  localparam int LINE_W  = ADDR_W + MAC_W;

  localparam logic [IDX_W:0]    ENTRIES_CNT = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(ENTRIES - 1);
  localparam logic [ADDR_W-1:0] GW_RESET    = 32'h0A00_0202;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_STORE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

/* rtl/ipmac_ram.sv */
module ipmac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ip_to_mac_address_cache.sv */
// channel | dir | tdata                              | tuser
// in_     | in  | [31:0] ip_address, [79:32] mac_in  | [0] operation
// out_    | out | [47:0] mac_out                     | [0] found, [1] known
// cfg_    | in  | [31:0] gateway_address             | -
//
// gateway address: answered from the gateway registers, going straight to the response state
// other addresses: a linear scan of up to ENTRIES table entries, with one
// table read per cycle
// one item in flight; the next input is taken while the result waits on out_
// rst_n clears valid bits, gateway mac, round-robin slot and control at once
module ip_to_mac_address_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [79:0]                   in_tdata,   // ip_address, mac_in
  input  logic                          in_tuser,   // operation
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ipmac_pkg::MAC_W-1:0]   out_tdata,  // mac_out
  output logic [1:0]                    out_tuser,  // found, known
  input  logic                          cfg_tvalid,
  output logic                          cfg_tready,
  input  logic [ipmac_pkg::ADDR_W-1:0]  cfg_tdata   // gateway_address
);

  localparam int IDX_W  = ipmac_pkg::IDX_W;
  localparam int ADDR_W = ipmac_pkg::ADDR_W;
  localparam int MAC_W  = ipmac_pkg::MAC_W;

  ipmac_pkg::state_t state_r, state_nxt;

  logic [ADDR_W-1:0]              gw_addr_r, gw_addr_nxt;
  logic [MAC_W-1:0]               gw_mac_r, gw_mac_nxt;
  logic [ipmac_pkg::ENTRIES-1:0]  valid_r, valid_nxt;
  logic [IDX_W-1:0]               slot_r, slot_nxt;
  logic                           op_r, op_nxt;
  logic [ADDR_W-1:0]              key_r, key_nxt;
  logic [MAC_W-1:0]               mac_r, mac_nxt;
  logic [IDX_W:0]                 rd_idx_r, rd_idx_nxt;
  logic                           chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]               chk_idx_r, chk_idx_nxt;
  logic                           res_found_r, res_found_nxt;
  logic [MAC_W-1:0]               res_mac_r, res_mac_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic                           out_known_r, out_known_nxt;
  logic [MAC_W-1:0]               out_mac_r, out_mac_nxt;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [ipmac_pkg::LINE_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]               ram_raddr;
  logic [ipmac_pkg::LINE_W-1:0]   ram_rdata;

  logic              in_xfer;
  logic              gw_hit;
  logic              hit;
  logic              miss_done;
  logic              out_free;
  logic [ADDR_W-1:0] rd_addr;
  logic [MAC_W-1:0]  rd_mac;

  ipmac_ram #(
    .WIDTH(ipmac_pkg::LINE_W),
    .DEPTH(ipmac_pkg::ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == ipmac_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign gw_hit     = (in_tdata[ADDR_W-1:0] == gw_addr_r);
  assign rd_addr    = ram_rdata[ADDR_W-1:0];
  assign rd_mac     = ram_rdata[ipmac_pkg::LINE_W-1:ADDR_W];
  assign hit        = chk_v_r && valid_r[chk_idx_r] && (rd_addr == key_r);
  assign miss_done  = chk_v_r && !hit && (chk_idx_r == ipmac_pkg::LAST_IDX);
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_tready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mac_r;
  assign out_tuser  = {out_known_r, out_found_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipmac_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = gw_hit ? ipmac_pkg::ST_RESP : ipmac_pkg::ST_SCAN;
        end
      end
      ipmac_pkg::ST_SCAN: begin
        if (hit || miss_done) begin
          state_nxt = ipmac_pkg::ST_RESP;
        end
      end
      ipmac_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = ipmac_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ipmac_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    gw_addr_nxt   = gw_addr_r;
    gw_mac_nxt    = gw_mac_r;
    valid_nxt     = valid_r;
    slot_nxt      = slot_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    mac_nxt       = mac_r;
    rd_idx_nxt    = rd_idx_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    res_found_nxt = res_found_r;
    res_mac_nxt   = res_mac_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_known_nxt = out_known_r;
    out_mac_nxt   = out_mac_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r;
    ram_wdata     = {mac_r, key_r};
    ram_raddr     = rd_idx_r[IDX_W-1:0];

    if (cfg_tvalid && cfg_tready) begin
      gw_addr_nxt = cfg_tdata;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ipmac_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_nxt     = in_tuser;
          key_nxt    = in_tdata[ADDR_W-1:0];
          mac_nxt    = in_tdata[ADDR_W+MAC_W-1:ADDR_W];
          rd_idx_nxt = '0;
          if (gw_hit) begin
            res_found_nxt = 1'b1;
            if (in_tuser == ipmac_pkg::OP_STORE) begin
              gw_mac_nxt  = in_tdata[ADDR_W+MAC_W-1:ADDR_W];
              res_mac_nxt = '0;
            end else begin
              res_mac_nxt = gw_mac_r;
            end
          end
        end
      end
      ipmac_pkg::ST_SCAN: begin
        if (rd_idx_r < ipmac_pkg::ENTRIES_CNT) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        if (hit) begin
          res_found_nxt = 1'b1;
          if (op_r == ipmac_pkg::OP_STORE) begin
            ram_we      = 1'b1;
            ram_waddr   = chk_idx_r;
            res_mac_nxt = '0;
          end else begin
            res_mac_nxt = rd_mac;
          end
        end else if (miss_done) begin
          res_mac_nxt = '0;
          if (op_r == ipmac_pkg::OP_STORE) begin
            res_found_nxt     = 1'b1;
            ram_we            = 1'b1;
            ram_waddr         = slot_r;
            valid_nxt[slot_r] = 1'b1;
            slot_nxt = (slot_r == ipmac_pkg::LAST_IDX) ? '0 : slot_r + 1'b1;
          end else begin
            res_found_nxt = 1'b0;
          end
        end
      end
      ipmac_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_known_nxt = res_found_r && (res_mac_r != '0);
          out_mac_nxt   = res_mac_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipmac_pkg::ST_IDLE;
      gw_addr_r   <= ipmac_pkg::GW_RESET;
      gw_mac_r    <= '0;
      valid_r     <= '0;
      slot_r      <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gw_addr_r   <= gw_addr_nxt;
      gw_mac_r    <= gw_mac_nxt;
      valid_r     <= valid_nxt;
      slot_r      <= slot_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    mac_r       <= mac_nxt;
    rd_idx_r    <= rd_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    res_found_r <= res_found_nxt;
    res_mac_r   <= res_mac_nxt;
    out_found_r <= out_found_nxt;
    out_known_r <= out_known_nxt;
    out_mac_r   <= out_mac_nxt;
  end

  a_known_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_known_r |-> out_found_r)
    else $error("known without found");

  a_we_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ipmac_pkg::ST_SCAN)
    else $error("table write outside scan");

  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ipmac_pkg::ST_SCAN && miss_done && op_r == ipmac_pkg::OP_STORE
    |=> valid_r[$past(slot_r)])
    else $error("filled slot not marked valid");

  a_load_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ipmac_pkg::ST_RESP)
    else $error("result loaded outside response state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ipmac_pkg::ST_SCAN |-> rd_idx_r <= ipmac_pkg::ENTRIES_CNT)
    else $error("scan index overrun");

endmodule
